// ----- rtl/parallel_printer_spooler_top_macros.svh -----
// ----------------------------------------------------------------------------
// Parallel printer spooler assertion macros
// Shared property shapes for the spooler's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef PARALLEL_PRINTER_SPOOLER_TOP_MACROS_SVH
`define PARALLEL_PRINTER_SPOOLER_TOP_MACROS_SVH

// same-cycle implication, reset masks the check
`define PPSP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, reset masks the check
`define PPSP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/ppsp_pkg.sv -----
// ----------------------------------------------------------------------------
// Parallel printer spooler package
// Types and printer port constants shared by the spooler modules.
// ----------------------------------------------------------------------------
package ppsp_pkg;

   localparam logic [7:0] CMD_IRQ_OFF     = 8'h0C;
   localparam logic [7:0] CMD_STROBE_LOW  = 8'h1C;
   localparam int         STATUS_OK_BIT   = 3;
   localparam int         QUEUE_DEPTH     = 2;
   localparam int         QUEUE_PW        = 1;

   typedef enum logic [1:0] {
      OP_CHAR,
      OP_READY,
      OP_SKIP
   } opkind_type;

   typedef struct packed {
      opkind_type kind;
      logic [7:0] char_byte;
   } op_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      logic busy;
      logic empty;
   } bk_status_type;

   typedef struct packed {
      logic       data_valid;
      logic [7:0] data_byte;
      logic [7:0] command_byte;
      logic       print_done;
      logic       accepted;
      logic [7:0] buffered_count;
   } rsp_type;

   typedef enum logic {
      BK_IDLE,
      BK_FETCH
   } bk_state_type;

endpackage

// ----- rtl/ppsp_front.sv -----
// ----------------------------------------------------------------------------
// Parallel printer spooler front end
// Accepts request beats and decodes them into spooler operations.
// ----------------------------------------------------------------------------
module ppsp_front
   import ppsp_pkg::*;
(
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         req_mode,
   input  logic [7:0]   req_char_in,
   input  logic [7:0]   req_status_in,
   input  q_status_type q_status,
   output logic         q_push,
   output op_type       q_op
);

   assign req_stall = q_status.full;
   assign q_push    = req_valid && !q_status.full;

   always_comb begin
      q_op.char_byte = req_char_in;
      if (!req_mode) begin
         q_op.kind = OP_CHAR;
      end else if (req_status_in[STATUS_OK_BIT]) begin
         q_op.kind = OP_READY;
      end else begin
         q_op.kind = OP_SKIP;
      end
   end

endmodule

// ----- rtl/ppsp_queue.sv -----
// ----------------------------------------------------------------------------
// Parallel printer spooler operation queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module ppsp_queue
   import ppsp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  op_type       push_op,
   input  logic         pop,
   output op_type       pop_op,
   output q_status_type status
);

   op_type                      entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PW:0]           cnt_ff, cnt_in;

   assign status.full  = (cnt_ff == (QUEUE_PW+1)'(QUEUE_DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign pop_op       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ----- rtl/ppsp_back.sv -----
// ----------------------------------------------------------------------------
// Parallel printer spooler back end
// Runs queued operations against the ring buffer and drives the response.
// ----------------------------------------------------------------------------
module ppsp_back
   import ppsp_pkg::*;
#(
   parameter int BUFFER_DEPTH = 128
)
(
   input  logic          clock,
   input  logic          reset,
   input  op_type        q_op,
   input  q_status_type  q_status,
   output logic          q_pop,
   input  logic          rsp_stall,
   output logic          rsp_valid,
   output rsp_type       rsp,
   output bk_status_type status
);

   localparam int PW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int CW = $clog2(BUFFER_DEPTH + 1);

   logic [7:0]     store_mem [BUFFER_DEPTH];
   logic [7:0]     rd_data_ff;
   bk_state_type   state_ff, state_in;
   logic [PW-1:0]  wp_ff, wp_in;
   logic [PW-1:0]  rp_ff, rp_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           busy_ff, busy_in;
   logic           rsp_valid_ff;
   rsp_type        rsp_ff, rsp_in;
   logic           load;
   logic           wr_en;
   logic           rd_en;
   logic           out_free;

   function automatic logic [PW-1:0] advance(input logic [PW-1:0] ptr);
      if (ptr == PW'(BUFFER_DEPTH - 1)) begin
         return '0;
      end
      return ptr + 1'b1;
   endfunction

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp          = rsp_ff;
   assign status.busy  = busy_ff;
   assign status.empty = (count_ff == '0);

   always_comb begin
      logic [CW+7:0] cnt_ext;
      state_in = state_ff;
      wp_in    = wp_ff;
      rp_in    = rp_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      q_pop    = 1'b0;
      load     = 1'b0;
      wr_en    = 1'b0;
      rd_en    = 1'b0;
      rsp_in   = '0;
      case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty && out_free) begin
               q_pop = 1'b1;
               case (q_op.kind)
                  OP_CHAR: begin
                     load = 1'b1;
                     if (!busy_ff) begin
                        rsp_in.data_valid   = 1'b1;
                        rsp_in.data_byte    = q_op.char_byte;
                        rsp_in.command_byte = CMD_STROBE_LOW;
                        rsp_in.accepted     = 1'b1;
                        busy_in             = 1'b1;
                     end else if (count_ff < CW'(BUFFER_DEPTH)) begin
                        wr_en           = 1'b1;
                        wp_in           = advance(wp_ff);
                        count_in        = count_ff + 1'b1;
                        rsp_in.accepted = 1'b1;
                     end
                  end
                  OP_READY: begin
                     if (count_ff == '0) begin
                        load                = 1'b1;
                        rsp_in.command_byte = CMD_IRQ_OFF;
                        rsp_in.print_done   = 1'b1;
                        busy_in             = 1'b0;
                     end else begin
                        rd_en    = 1'b1;
                        rp_in    = advance(rp_ff);
                        count_in = count_ff - 1'b1;
                        state_in = BK_FETCH;
                     end
                  end
                  default: begin
                     load = 1'b1;
                  end
               endcase
            end
         end
         BK_FETCH: begin
            load                = 1'b1;
            rsp_in.data_valid   = 1'b1;
            rsp_in.data_byte    = rd_data_ff;
            rsp_in.command_byte = CMD_STROBE_LOW;
            state_in            = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
      cnt_ext               = {8'b0, count_in};
      rsp_in.buffered_count = cnt_ext[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
         busy_ff  <= busy_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wp_ff] <= q_op.char_byte;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rp_ff];
      end
   end

endmodule

// ----- rtl/parallel_printer_spooler_top.sv -----
// ----------------------------------------------------------------------------
// Parallel printer spooler top level
// Request beats carry characters or printer-ready events; each request gives
// exactly one response beat, in order. Requests enter a two-entry queue at
// one per cycle unless the queue is full. Most operations finish in the back
// end's idle state; a ready event that sends a buffered character also passes
// through the fetch state, as the ring buffer has a registered read port.
// The buffer holds BUFFER_DEPTH characters and needs no clearing after reset.
// ----------------------------------------------------------------------------
`include "parallel_printer_spooler_top_macros.svh"

module parallel_printer_spooler_top
   import ppsp_pkg::*;
#(
   parameter int BUFFER_DEPTH = 128
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_mode,
   input  logic [7:0] req_char_in,
   input  logic [7:0] req_status_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_data_valid,
   output logic [7:0] rsp_data_byte,
   output logic [7:0] rsp_command_byte,
   output logic       rsp_print_done,
   output logic       rsp_accepted,
   output logic [7:0] rsp_buffered_count
);

   q_status_type  q_status;
   bk_status_type bk_status;
   op_type        push_op;
   op_type        pop_op;
   logic          q_push;
   logic          q_pop;
   rsp_type       rsp;

   ppsp_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_char_in   (req_char_in),
      .req_status_in (req_status_in),
      .q_status      (q_status),
      .q_push        (q_push),
      .q_op          (push_op)
   );

   ppsp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_op (push_op),
      .pop     (q_pop),
      .pop_op  (pop_op),
      .status  (q_status)
   );

   ppsp_back #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_op      (pop_op),
      .q_status  (q_status),
      .q_pop     (q_pop),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .status    (bk_status)
   );

   assign rsp_data_valid     = rsp.data_valid;
   assign rsp_data_byte      = rsp.data_byte;
   assign rsp_command_byte   = rsp.command_byte;
   assign rsp_print_done     = rsp.print_done;
   assign rsp_accepted       = rsp.accepted;
   assign rsp_buffered_count = rsp.buffered_count;

   `PPSP_ASSERT_SAME(a_idle_empty, !bk_status.busy, bk_status.empty, "idle with chars buffered")
   `PPSP_ASSERT_SAME(a_strobe_cmd, rsp_valid && rsp_data_valid,
      rsp_command_byte == CMD_STROBE_LOW && !rsp_print_done, "strobe beat malformed")
   `PPSP_ASSERT_SAME(a_done_cmd, rsp_valid && rsp_print_done,
      rsp_command_byte == CMD_IRQ_OFF && rsp_buffered_count == 8'd0, "done beat malformed")
   `PPSP_ASSERT_NEXT(a_done_idle, rsp_valid && !rsp_stall && rsp_print_done && q_status.empty,
      !bk_status.busy, "printing flag kept after done")

endmodule

// ----- sim/parallel_printer_spooler_tb.sv -----
// ----------------------------------------------------------------------------
// Parallel printer spooler testbench
// Drives character and printer-ready beats into the spooler, tracks the ring
// buffer and printing flag in a scoreboard, and checks every response beat
// field by field in order. Random phases fill, drain and mix the buffer so
// that overflow, drain-to-done and error status all recur under random
// response stalls and random idle gaps between request beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
   import ppsp_pkg::*;

   localparam int          SPOOL_DEPTH  = 128;
   localparam logic        MODE_CHAR    = 1'b0;
   localparam logic        MODE_READY   = 1'b1;
   localparam int          RANDOM_BEATS = 1500;
   localparam int          CYCLE_LIMIT  = 1000000;
   localparam int          HOLD_CYCLES  = 400;
   localparam int          HOLD_AT_BEAT = 300;

   typedef struct {
      logic       mode;
      logic [7:0] ch;
      logic [7:0] status;
   } spool_req_type;

   typedef enum { PH_FILL, PH_DRAIN, PH_MIX } phase_kind_type;

   class spool_scoreboard_type;
      logic [7:0]  ring [SPOOL_DEPTH];
      int unsigned wr_idx;
      int unsigned rd_idx;
      int unsigned queued;
      bit          printing;
      rsp_type     expected_q [$];
      int unsigned errors;

      function new();
         wr_idx   = 0;
         rd_idx   = 0;
         queued   = 0;
         printing = 1'b0;
         errors   = 0;
      endfunction

      function void note_request(spool_req_type b);
         rsp_type r;
         r = '0;
         if (b.mode == MODE_CHAR) begin
            if (!printing) begin
               r.data_valid   = 1'b1;
               r.data_byte    = b.ch;
               r.command_byte = CMD_STROBE_LOW;
               r.accepted     = 1'b1;
               printing       = 1'b1;
            end else if (queued < SPOOL_DEPTH) begin
               ring[wr_idx] = b.ch;
               wr_idx       = (wr_idx + 1) % SPOOL_DEPTH;
               queued++;
               r.accepted   = 1'b1;
            end
         end else if (b.status[STATUS_OK_BIT]) begin
            if (queued == 0) begin
               r.command_byte = CMD_IRQ_OFF;
               r.print_done   = 1'b1;
               printing       = 1'b0;
            end else begin
               r.data_valid   = 1'b1;
               r.data_byte    = ring[rd_idx];
               r.command_byte = CMD_STROBE_LOW;
               rd_idx         = (rd_idx + 1) % SPOOL_DEPTH;
               queued--;
            end
         end
         r.buffered_count = 8'(queued);
         expected_q.push_back(r);
      endfunction

      function void cmp_field(string name, int unsigned exp_v, int unsigned got_v);
         if (exp_v != got_v) begin
            errors++;
            $display("%0t mismatch %s expected %0h actual %0h", $time, name, exp_v, got_v);
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type exp_r;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t unexpected response beat expected none actual %h", $time, got);
            return;
         end
         exp_r = expected_q.pop_front();
         cmp_field("data_valid", exp_r.data_valid, got.data_valid);
         cmp_field("data_byte", exp_r.data_byte, got.data_byte);
         cmp_field("command_byte", exp_r.command_byte, got.command_byte);
         cmp_field("print_done", exp_r.print_done, got.print_done);
         cmp_field("accepted", exp_r.accepted, got.accepted);
         cmp_field("buffered_count", exp_r.buffered_count, got.buffered_count);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_mode = 1'b0;
   logic [7:0] req_char_in = 8'h00;
   logic [7:0] req_status_in = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_data_valid;
   logic [7:0] rsp_data_byte;
   logic [7:0] rsp_command_byte;
   logic       rsp_print_done;
   logic       rsp_accepted;
   logic [7:0] rsp_buffered_count;

   spool_scoreboard_type sb;
   int unsigned          beats_sent;
   int unsigned          cycle_count;

   parallel_printer_spooler_top #(.BUFFER_DEPTH(SPOOL_DEPTH)) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_char_in        (req_char_in),
      .req_status_in      (req_status_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_data_valid     (rsp_data_valid),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_command_byte   (rsp_command_byte),
      .rsp_print_done     (rsp_print_done),
      .rsp_accepted       (rsp_accepted),
      .rsp_buffered_count (rsp_buffered_count)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("parallel_printer_spooler_top verification failed");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 2);
      if (r < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   function automatic spool_req_type make_beat(phase_kind_type k);
      spool_req_type b;
      int            ready_pct;
      case (k)
         PH_FILL:  ready_pct = 10;
         PH_DRAIN: ready_pct = 90;
         default:  ready_pct = 50;
      endcase
      b.mode   = ($urandom_range(0, 99) < ready_pct) ? MODE_READY : MODE_CHAR;
      b.ch     = 8'($urandom_range(0, 255));
      b.status = 8'($urandom_range(0, 255));
      b.status[STATUS_OK_BIT] = ($urandom_range(0, 99) < 85);
      return b;
   endfunction

   task automatic send_beat(spool_req_type b);
      req_valid     <= 1'b1;
      req_mode      <= b.mode;
      req_char_in   <= b.ch;
      req_status_in <= b.status;
      do @(posedge clock); while (req_stall);
      sb.note_request(b);
      beats_sent++;
   endtask

   task automatic idle_gap(int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // response side: check, then choose next stall
   initial begin
      int unsigned rsp_beats;
      int          stall_left;
      int          free_left;
      bit          held;
      rsp_type     got;
      rsp_beats  = 0;
      stall_left = 0;
      free_left  = 0;
      held       = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.data_valid     = rsp_data_valid;
            got.data_byte      = rsp_data_byte;
            got.command_byte   = rsp_command_byte;
            got.print_done     = rsp_print_done;
            got.accepted       = rsp_accepted;
            got.buffered_count = rsp_buffered_count;
            sb.check_response(got);
            rsp_beats++;
         end
         if (!held && rsp_beats >= HOLD_AT_BEAT) begin
            held       = 1'b1;
            stall_left = HOLD_CYCLES;
            free_left  = 0;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (free_left > 0) begin
            rsp_stall <= 1'b0;
            free_left--;
         end else begin
            rsp_stall  <= 1'b0;
            free_left  = ($urandom_range(0, 99) < 20) ? $urandom_range(30, 120)
                                                      : $urandom_range(0, 10);
            stall_left = pick_gap();
         end
      end
   end

   initial begin
      phase_kind_type kind;
      int             phase_len;
      bit             no_idle;
      bit             paused;
      sb          = new();
      beats_sent  = 0;
      cycle_count = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_beat('{MODE_READY, 8'hC3, 8'h08});
      send_beat('{MODE_READY, 8'hFF, 8'h00});
      send_beat('{MODE_CHAR,  8'h00, 8'hFF});
      send_beat('{MODE_CHAR,  8'hFF, 8'h00});
      send_beat('{MODE_CHAR,  8'hA5, 8'h08});
      idle_gap(3);
      send_beat('{MODE_READY, 8'h00, 8'hF7});
      send_beat('{MODE_READY, 8'h5A, 8'hFF});
      send_beat('{MODE_READY, 8'hFF, 8'h08});
      send_beat('{MODE_READY, 8'h3C, 8'h5A});
      send_beat('{MODE_READY, 8'h00, 8'h08});
      send_beat('{MODE_CHAR,  8'h55, 8'hAA});
      send_beat('{MODE_CHAR,  8'hAA, 8'h55});
      send_beat('{MODE_READY, 8'h81, 8'h00});
      send_beat('{MODE_READY, 8'h7E, 8'h0F});
      send_beat('{MODE_READY, 8'h18, 8'h88});
      pause_until_drained();

      beats_sent = 0;
      paused     = 1'b0;
      kind       = PH_FILL;
      phase_len  = 180;
      no_idle    = 1'b0;
      while (beats_sent < RANDOM_BEATS) begin
         repeat (phase_len) begin
            send_beat(make_beat(kind));
            if (!no_idle) idle_gap(pick_gap());
         end
         if (!paused && beats_sent >= RANDOM_BEATS / 2) begin
            paused = 1'b1;
            pause_until_drained();
         end
         if (kind == PH_FILL && phase_len == 180) begin
            kind      = PH_DRAIN;
            phase_len = 170;
         end else begin
            case ($urandom_range(0, 2))
               0:       kind = PH_FILL;
               1:       kind = PH_DRAIN;
               default: kind = PH_MIX;
            endcase
            phase_len = $urandom_range(10, 200);
         end
         no_idle = ($urandom_range(0, 3) == 0);
      end

      pause_until_drained();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("parallel_printer_spooler_top verification clean");
      end else begin
         $display("parallel_printer_spooler_top verification failed");
      end
      $finish;
   end

endmodule
